// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define AVD_ASSERT_ALWAYS(lbl, clk_s, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (prop)) \
		else $error(msg);

// implication checked in the same cycle
`define AVD_ASSERT_IMPLIES(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/avd_pkg.sv =====
`default_nettype none

package avd_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ANG_TAB_LEN   = 24;
	localparam int CORDIC_RUN    = (CORDIC_STAGES < ANG_TAB_LEN) ? CORDIC_STAGES : ANG_TAB_LEN;
	localparam int FRAC_BITS     = 16;
	localparam int XY_W          = 30;
	localparam int MAG_W         = XY_W - 1;
	localparam int ANG_W         = 32;
	localparam int PROD_W        = MAG_W + 32;
	localparam int LATENCY       = CORDIC_RUN + 3;

	localparam logic [4:0]      TYPE_CODE_VEL = 5'd19;
	localparam logic [2:0]      SUB_GND_1     = 3'd1;
	localparam logic [2:0]      SUB_GND_2     = 3'd2;
	localparam logic [31:0]     GAIN_Q32      = 32'h9B74EDA8;
	localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [ANG_W-1:0] ANG_ROUND    = 32'h0000_8000;
	localparam logic [13:0]     SPEED_MAX     = 14'h3FFF;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_TC  = 1'b1;
	localparam logic KIND_GROUND    = 1'b0;
	localparam logic KIND_AIR       = 1'b1;

	// side data that rides along the cordic pipeline
	typedef struct packed {
		logic               status;
		logic               kind;
		logic               zero;
		logic [13:0]        air_speed;
		logic [15:0]        air_head;
		logic signed [15:0] rate;
	} side_t;

	// atan(2^-i) in units of 2^32 per turn
	function automatic logic [ANG_W-1:0] atan_tab(input int idx);
		logic [ANG_W-1:0] a;
		case (idx)
			0:       a = 32'h20000000;
			1:       a = 32'h12E4051E;
			2:       a = 32'h09FB385B;
			3:       a = 32'h051111D4;
			4:       a = 32'h028B0D43;
			5:       a = 32'h0145D7E1;
			6:       a = 32'h00A2F61E;
			7:       a = 32'h00517C55;
			8:       a = 32'h0028BE53;
			9:       a = 32'h00145F2F;
			10:      a = 32'h000A2F98;
			11:      a = 32'h000517CC;
			12:      a = 32'h00028BE6;
			13:      a = 32'h000145F3;
			14:      a = 32'h0000A2FA;
			15:      a = 32'h0000517D;
			16:      a = 32'h000028BE;
			17:      a = 32'h0000145F;
			18:      a = 32'h00000A30;
			19:      a = 32'h00000518;
			20:      a = 32'h0000028C;
			21:      a = 32'h00000146;
			22:      a = 32'h000000A3;
			23:      a = 32'h00000051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/avd_cordic.sv =====
`default_nettype none

// vectoring cordic, one micro-rotation per register stage
module avd_cordic (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	input  wire logic signed [avd_pkg::XY_W-1:0] in_x,
	input  wire logic signed [avd_pkg::XY_W-1:0] in_y,
	input  wire logic [avd_pkg::ANG_W-1:0]       in_z,
	input  wire avd_pkg::side_t                  in_side,
	output logic                                 out_valid,
	output logic signed [avd_pkg::XY_W-1:0]      out_x,
	output logic [avd_pkg::ANG_W-1:0]            out_z,
	output avd_pkg::side_t                       out_side
);

	localparam int N = avd_pkg::CORDIC_RUN;

	logic                             vld_s  [N];
	logic signed [avd_pkg::XY_W-1:0]  x_s    [N];
	logic signed [avd_pkg::XY_W-1:0]  y_s    [N];
	logic [avd_pkg::ANG_W-1:0]        z_s    [N];
	avd_pkg::side_t                   side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic                            v_in;
		logic signed [avd_pkg::XY_W-1:0] x_in;
		logic signed [avd_pkg::XY_W-1:0] y_in;
		logic [avd_pkg::ANG_W-1:0]       z_in;
		avd_pkg::side_t                  sd_in;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign x_in  = in_x;
			assign y_in  = in_y;
			assign z_in  = in_z;
			assign sd_in = in_side;
		end else begin : g_next
			assign v_in  = vld_s[k-1];
			assign x_in  = x_s[k-1];
			assign y_in  = y_s[k-1];
			assign z_in  = z_s[k-1];
			assign sd_in = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end

		// y >= 0 turns clockwise, floor shifts on both coordinates
		always_ff @(posedge clk) begin
			if (v_in) begin
				side_s[k] <= sd_in;
				if (!y_in[avd_pkg::XY_W-1]) begin
					x_s[k] <= x_in + (y_in >>> k);
					y_s[k] <= y_in - (x_in >>> k);
					z_s[k] <= z_in + avd_pkg::atan_tab(k);
				end else begin
					x_s[k] <= x_in - (y_in >>> k);
					y_s[k] <= y_in + (x_in >>> k);
					z_s[k] <= z_in - avd_pkg::atan_tab(k);
				end
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_x     = x_s[N-1];
	assign out_z     = z_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

`default_nettype wire

// ===== rtl/airborne_velocity_decode.sv =====
// path: a word taken under start runs through the registers for decode, one stage per
// micro-rotation, gain and output before it reaches the result ports
// throughput: one word per cycle, busy stays low and every stage moves each cycle
// the result ports hold for one cycle under done; the receiver cannot stall
// reset: arst_n clears all valid bits at once, payload registers are not reset
`default_nettype none

module airborne_velocity_decode (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire [55:0]        me_field,
	output logic              done,
	output logic              status,
	output logic              speed_kind,
	output logic [13:0]       speed_eighths,
	output logic [15:0]       heading_angle,
	output logic signed [15:0] vertical_rate
);

	// ---------------------------------------------------------------
	// field extraction (first transmitted bit is bit 55)
	// ---------------------------------------------------------------
	logic [4:0] type_code;
	logic [2:0] subtype;
	logic       east_sign;
	logic [9:0] east_raw;
	logic       north_sign;
	logic [9:0] north_raw;
	logic       rate_sign;
	logic [8:0] rate_raw;

	assign type_code  = me_field[55:51];
	assign subtype    = me_field[50:48];
	assign east_sign  = me_field[42];
	assign east_raw   = me_field[41:32];
	assign north_sign = me_field[31];
	assign north_raw  = me_field[30:21];
	assign rate_sign  = me_field[19];
	assign rate_raw   = me_field[18:10];

	// the pipeline never stalls, so a new word is taken every cycle
	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---------------------------------------------------------------
	// decode: signed components, rate, airspeed fields, cordic start
	// ---------------------------------------------------------------
	logic signed [10:0]               east_v, north_v, east_c, north_c;
	logic signed [9:0]                rate_m1;
	logic signed [15:0]               rate_abs, rate_v;
	logic signed [avd_pkg::XY_W-1:0]  x_init, y_init;
	avd_pkg::side_t                   side_in;

	always_comb begin
		// raw zero means not available but is taken literally as -1
		east_v  = $signed({1'b0, east_raw}) - 11'sd1;
		north_v = $signed({1'b0, north_raw}) - 11'sd1;
		east_c  = east_sign ? -east_v : east_v;
		north_c = north_sign ? -north_v : north_v;

		rate_m1  = $signed({1'b0, rate_raw}) - 10'sd1;
		rate_abs = 16'(rate_m1) <<< 6;
		rate_v   = rate_sign ? -rate_abs : rate_abs;

		x_init = avd_pkg::XY_W'(north_c) <<< avd_pkg::FRAC_BITS;
		y_init = avd_pkg::XY_W'(east_c) <<< avd_pkg::FRAC_BITS;

		side_in.status    = (type_code == avd_pkg::TYPE_CODE_VEL) ?
		                    avd_pkg::STATUS_OK : avd_pkg::STATUS_BAD_TC;
		side_in.kind      = (subtype == avd_pkg::SUB_GND_1 || subtype == avd_pkg::SUB_GND_2) ?
		                    avd_pkg::KIND_GROUND : avd_pkg::KIND_AIR;
		side_in.zero      = (east_c == 11'sd0) && (north_c == 11'sd0);
		side_in.air_speed = {1'b0, north_raw, 3'b000};
		side_in.air_head  = {east_raw, 6'b000000};
		side_in.rate      = rate_v;
	end

	logic                            vld_s1;
	logic signed [avd_pkg::XY_W-1:0] x_s1, y_s1;
	logic [avd_pkg::ANG_W-1:0]       z_s1;
	avd_pkg::side_t                  side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	// south half plane folds over to the north, angle starts at half a turn
	always_ff @(posedge clk) begin
		if (accept) begin
			side_s1 <= side_in;
			if (north_c < 11'sd0) begin
				x_s1 <= -x_init;
				y_s1 <= -y_init;
				z_s1 <= avd_pkg::HALF_TURN;
			end else begin
				x_s1 <= x_init;
				y_s1 <= y_init;
				z_s1 <= '0;
			end
		end
	end

	// ---------------------------------------------------------------
	// cordic pipeline, one rotation per stage
	// ---------------------------------------------------------------
	logic                            vld_sc;
	logic signed [avd_pkg::XY_W-1:0] x_sc;
	logic [avd_pkg::ANG_W-1:0]       z_sc;
	avd_pkg::side_t                  side_sc;

	avd_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_x      (x_s1),
		.in_y      (y_s1),
		.in_z      (z_s1),
		.in_side   (side_s1),
		.out_valid (vld_sc),
		.out_x     (x_sc),
		.out_z     (z_sc),
		.out_side  (side_sc)
	);

	// ---------------------------------------------------------------
	// gain stage: x times the inverse cordic gain, heading rounding
	// ---------------------------------------------------------------
	logic                          vld_s2;
	logic [avd_pkg::PROD_W-1:0]    prod_s2;
	logic [15:0]                   head_s2;
	avd_pkg::side_t                side_s2;
	logic [avd_pkg::ANG_W-1:0]     z_rnd;

	// x is never negative once the vector sits in the north half plane
	assign z_rnd = z_sc + avd_pkg::ANG_ROUND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_sc) begin
			prod_s2 <= avd_pkg::PROD_W'(x_sc[avd_pkg::MAG_W-1:0]) *
			           avd_pkg::PROD_W'(avd_pkg::GAIN_Q32);
			head_s2 <= z_rnd[31:16];
			side_s2 <= side_sc;
		end
	end

	// ---------------------------------------------------------------
	// output stage: round, saturate, select by status and kind
	// ---------------------------------------------------------------
	logic [avd_pkg::PROD_W:0] mag_sum;
	logic [avd_pkg::PROD_W-45:0] mag_full;
	logic [13:0]              mag_sat;

	always_comb begin
		mag_sum  = {1'b0, prod_s2} + ((avd_pkg::PROD_W+1)'(1) << 44);
		mag_full = mag_sum[avd_pkg::PROD_W:45];
		mag_sat  = (mag_full > (avd_pkg::PROD_W-44)'(avd_pkg::SPEED_MAX)) ?
		           avd_pkg::SPEED_MAX : mag_full[13:0];
	end

	logic               done_s3;
	logic               status_s3;
	logic               kind_s3;
	logic [13:0]        speed_s3;
	logic [15:0]        head_s3;
	logic signed [15:0] rate_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			status_s3 <= side_s2.status;
			if (side_s2.status == avd_pkg::STATUS_BAD_TC) begin
				// wrong type code: everything else reads zero
				kind_s3  <= avd_pkg::KIND_GROUND;
				speed_s3 <= '0;
				head_s3  <= '0;
				rate_s3  <= '0;
			end else if (side_s2.kind == avd_pkg::KIND_AIR) begin
				kind_s3  <= avd_pkg::KIND_AIR;
				speed_s3 <= side_s2.air_speed;
				head_s3  <= side_s2.air_head;
				rate_s3  <= side_s2.rate;
			end else begin
				// a zero vector has neither speed nor heading
				kind_s3  <= avd_pkg::KIND_GROUND;
				speed_s3 <= side_s2.zero ? 14'd0 : mag_sat;
				head_s3  <= side_s2.zero ? 16'd0 : head_s2;
				rate_s3  <= side_s2.rate;
			end
		end
	end

	assign done          = done_s3;
	assign status        = status_s3;
	assign speed_kind    = kind_s3;
	assign speed_eighths = speed_s3;
	assign heading_angle = head_s3;
	assign vertical_rate = rate_s3;

endmodule

`default_nettype wire

// ===== rtl/avd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

// watches the result ports of the velocity decoder
module avd_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               busy,
	input wire               done,
	input wire               status,
	input wire               speed_kind,
	input wire [13:0]        speed_eighths,
	input wire [15:0]        heading_angle,
	input wire signed [15:0] vertical_rate
);

	logic bad_clear;
	logic air_aligned;

	assign bad_clear   = !speed_kind && speed_eighths == 14'd0 && heading_angle == 16'd0 &&
	                     vertical_rate == 16'sd0;
	assign air_aligned = !status && speed_eighths[2:0] == 3'd0 && heading_angle[5:0] == 6'd0 &&
	                     speed_eighths <= 14'd8184;

	// pipeline never pushes back
	`AVD_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy, "busy raised")

	// wrong type code clears every other field
	`AVD_ASSERT_IMPLIES(a_bad_tc_zero, clk, arst_n, done && status, bad_clear, "bad tc not cleared")

	// airspeed words are raw fields scaled by 8 and 64
	`AVD_ASSERT_IMPLIES(a_air_scaled, clk, arst_n, done && speed_kind, air_aligned, "air misaligned")

	// climb rate always comes in steps of 64 ft/min
	`AVD_ASSERT_IMPLIES(a_rate_step, clk, arst_n, done, vertical_rate[5:0] == 6'd0, "rate not x64")

	// no result word in the first cycle out of reset
	`AVD_ASSERT_IMPLIES(a_no_early_done, clk, arst_n, $rose(arst_n), !done, "word out of reset")

endmodule

bind airborne_velocity_decode avd_checker u_avd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.speed_kind    (speed_kind),
	.speed_eighths (speed_eighths),
	.heading_angle (heading_angle),
	.vertical_rate (vertical_rate)
);

`default_nettype wire
